// ----- src/xfw_pkg.sv -----
// ----------------------------------------------------------------------------
// xfw_pkg
// shared types and constants of the packet frame walker
// ----------------------------------------------------------------------------
`default_nettype none

package xfw_pkg;

  localparam int COUNT_W  = 14;   // frame count and frame index
  localparam int SIZE_W   = 16;   // reported frame size
  localparam int QUERY_W  = 14;   // query bit offset
  localparam int FIRST_W  = 16;   // biased first-frame offset, also compare width
  localparam int WIN_W    = 24;   // three-byte fetch window
  localparam int HC_W     = 6;    // header frame count field

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [2:0]         META_XMA2 = 3'd1;

  // walk sequencer states
  typedef enum logic [7:0] {
    W_IDLE   = 8'b0000_0001,
    W_FETCH  = 8'b0000_0010,
    W_HEAD   = 8'b0000_0100,
    W_CHECK  = 8'b0000_1000,
    W_FRAME  = 8'b0001_0000,
    W_CONT   = 8'b0010_0000,
    W_FINISH = 8'b0100_0000,
    W_DONE   = 8'b1000_0000
  } walk_state_t;

  // result of one walk
  typedef struct packed {
    logic               mismatch;
    logic [SIZE_W-1:0]  size;
    logic [COUNT_W-1:0] frame;
    logic [COUNT_W-1:0] count;
  } walk_res_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] r;
    r = (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_W'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/xfw_ram.sv -----
// ----------------------------------------------------------------------------
// xfw_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module xfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/xfw_walker.sv -----
// ----------------------------------------------------------------------------
// xfw_walker
// header decode and frame chain walk over the packet store
// ----------------------------------------------------------------------------
`default_nettype none

module xfw_walker #(
  parameter int PACKET_BYTES       = 2048,
  parameter int FRAME_HEADER_BITS  = 15,
  parameter int PACKET_HEADER_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [xfw_pkg::QUERY_W-1:0]       query,
  output logic                                   rd_en,
  output logic      [$clog2(PACKET_BYTES)-1:0]   rd_addr,
  input  wire logic [7:0]                        rd_data,
  output logic                                   idle,
  output logic                                   done,
  input  wire logic                              take,
  output xfw_pkg::walk_res_t                     res
);

  localparam int ADDR_W      = $clog2(PACKET_BYTES);
  localparam int PACKET_BITS = PACKET_BYTES * 8;
  localparam int POS_W       = $clog2(PACKET_BITS + 1);
  localparam int FW          = xfw_pkg::FIRST_W;
  localparam int CW          = xfw_pkg::COUNT_W;
  localparam int WW          = xfw_pkg::WIN_W;

  localparam logic [FRAME_HEADER_BITS-1:0] HDR_ALL_ONES = {FRAME_HEADER_BITS{1'b1}};

  xfw_pkg::walk_state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [1:0]                    fcnt_r, fcnt_nxt;
  logic [WW-1:0]                 win_r, win_nxt;
  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [xfw_pkg::QUERY_W-1:0]   query_r, query_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [CW-1:0]                 frame_r, frame_nxt;
  logic [xfw_pkg::SIZE_W-1:0]    size_r, size_nxt;
  logic                          split_r, split_nxt;
  logic                          mismatch_r, mismatch_nxt;
  logic                          xma2_r, xma2_nxt;
  logic [xfw_pkg::HC_W-1:0]      hc_r, hc_nxt;

  logic [ADDR_W:0]               addr_sum;
  logic [WW-1:0]                 shifted;
  logic [FRAME_HEADER_BITS-1:0]  fs;
  logic [FW-1:0]                 remaining;
  logic [FW-1:0]                 first;
  logic [FW-1:0]                 pos_ext;
  logic [FW-1:0]                 query_ext;

  // fetch window: three bytes starting at the byte that holds pos
  assign addr_sum = (ADDR_W+1)'(pos_r >> 3) + (ADDR_W+1)'(fcnt_r);
  assign rd_addr  = (addr_sum >= (ADDR_W+1)'(PACKET_BYTES)) ? '0 : addr_sum[ADDR_W-1:0];
  assign rd_en    = (state_r == xfw_pkg::W_FETCH) && (fcnt_r != 2'd3);

  assign shifted   = win_r << pos_r[2:0];
  assign fs        = shifted[WW-1 -: FRAME_HEADER_BITS];
  assign pos_ext   = FW'(pos_r);
  assign query_ext = FW'(query_r);
  assign remaining = FW'(PACKET_BITS) - pos_ext;
  assign first     = FW'({win_r[17:16], win_r[15:8], win_r[7:3]}) + FW'(PACKET_HEADER_BITS);

  assign idle = (state_r == xfw_pkg::W_IDLE);
  assign done = (state_r == xfw_pkg::W_DONE);
  assign res  = '{mismatch: mismatch_r, size: size_r, frame: frame_r, count: count_r};

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    fcnt_nxt     = fcnt_r;
    win_nxt      = win_r;
    pos_nxt      = pos_r;
    query_nxt    = query_r;
    count_nxt    = count_r;
    frame_nxt    = frame_r;
    size_nxt     = size_r;
    split_nxt    = split_r;
    mismatch_nxt = mismatch_r;
    xma2_nxt     = xma2_r;
    hc_nxt       = hc_r;
    unique case (state_r)
      xfw_pkg::W_IDLE: begin
        if (start) begin
          query_nxt = query;
          pos_nxt   = '0;
          fcnt_nxt  = '0;
          ret_nxt   = xfw_pkg::W_HEAD;
          state_nxt = xfw_pkg::W_FETCH;
        end
      end
      xfw_pkg::W_FETCH: begin
        if (fcnt_r != 2'd0) begin
          win_nxt = {win_r[WW-9:0], rd_data};
        end
        fcnt_nxt = fcnt_r + 2'd1;
        if (fcnt_r == 2'd3) begin
          state_nxt = ret_r;
        end
      end
      xfw_pkg::W_HEAD: begin
        // window holds bytes 0..2
        hc_nxt       = win_r[23:18];
        xma2_nxt     = (win_r[2:0] == xfw_pkg::META_XMA2);
        pos_nxt      = (first < FW'(PACKET_BITS)) ? POS_W'(first) : POS_W'(PACKET_BITS);
        count_nxt    = '0;
        split_nxt    = 1'b0;
        mismatch_nxt = 1'b0;
        if (query_ext < first) begin
          frame_nxt = '0;
          size_nxt  = first - query_ext;
        end else begin
          frame_nxt = '0;
          size_nxt  = '0;
        end
        state_nxt = xfw_pkg::W_CHECK;
      end
      xfw_pkg::W_CHECK: begin
        if (remaining < FW'(FRAME_HEADER_BITS)) begin
          split_nxt = (count_r != '0) && (remaining != '0);
          state_nxt = xfw_pkg::W_FINISH;
        end else begin
          fcnt_nxt  = '0;
          ret_nxt   = xfw_pkg::W_FRAME;
          state_nxt = xfw_pkg::W_FETCH;
        end
      end
      xfw_pkg::W_FRAME: begin
        if (fs == '0 || fs == HDR_ALL_ONES) begin
          state_nxt = xfw_pkg::W_FINISH;
        end else begin
          if (pos_ext == query_ext) begin
            frame_nxt = count_r;
            size_nxt  = xfw_pkg::SIZE_W'(fs);
          end
          count_nxt = xfw_pkg::sat_inc(count_r);
          if (FW'(fs) > remaining) begin
            state_nxt = xfw_pkg::W_FINISH;
          end else begin
            // step to the continuation bit at the frame's end
            pos_nxt   = POS_W'(pos_ext + FW'(fs) - FW'(1));
            fcnt_nxt  = '0;
            ret_nxt   = xfw_pkg::W_CONT;
            state_nxt = xfw_pkg::W_FETCH;
          end
        end
      end
      xfw_pkg::W_CONT: begin
        pos_nxt   = pos_r + POS_W'(1);
        state_nxt = shifted[WW-1] ? xfw_pkg::W_CHECK : xfw_pkg::W_FINISH;
      end
      xfw_pkg::W_FINISH: begin
        if (xma2_r) begin
          if (CW'(hc_r) > count_r) begin
            if (size_r == '0) begin
              frame_nxt = count_r;
            end
            count_nxt = CW'(hc_r);
          end else if (CW'(hc_r) != count_r) begin
            mismatch_nxt = 1'b1;
          end
        end else if (split_r) begin
          if (size_r == '0) begin
            frame_nxt = count_r;
          end
          count_nxt = xfw_pkg::sat_inc(count_r);
        end
        state_nxt = xfw_pkg::W_DONE;
      end
      xfw_pkg::W_DONE: begin
        if (take) begin
          state_nxt = xfw_pkg::W_IDLE;
        end
      end
      default: begin
        state_nxt = xfw_pkg::W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xfw_pkg::W_IDLE;
      ret_r   <= xfw_pkg::W_HEAD;
      fcnt_r  <= '0;
      pos_r   <= '0;
      query_r <= '0;
      count_r <= '0;
      frame_r <= '0;
      size_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      fcnt_r  <= fcnt_nxt;
      pos_r   <= pos_nxt;
      query_r <= query_nxt;
      count_r <= count_nxt;
      frame_r <= frame_nxt;
      size_r  <= size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    split_r    <= split_nxt;
    mismatch_r <= mismatch_nxt;
    xma2_r     <= xma2_nxt;
    hc_r       <= hc_nxt;
  end

endmodule

`default_nettype wire

// ----- src/xma_packet_frame_walker.sv -----
// ----------------------------------------------------------------------------
// xma_packet_frame_walker
// loads an audio packet into a byte store and walks its frame header chain
// ----------------------------------------------------------------------------
// bytes load at one transfer per cycle into a single-port-read packet ram while the
// walker is idle; the transfer with tlast starts a walk that reads the header, then
// each frame header and continuation bit, until a clear continuation bit, the packet
// end, a stop header or a frame overrun ends the chain; out_tvalid rises and in_tready
// returns once an output register takes the result, so loading resumes; while it is
// full a finished walk holds the input off; reset clears load index, walk and valid
// ----------------------------------------------------------------------------
`default_nettype none

module xma_packet_frame_walker #(
  parameter int PACKET_BYTES       = 2048,
  parameter int FRAME_HEADER_BITS  = 15,
  parameter int PACKET_HEADER_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // packet_byte[7:0], frame_offset[21:8], zero pad
  input  wire logic        in_tlast,   // last_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [47:0] out_tdata,  // frame_count[13:0], current_frame[27:14],
                                       // current_frame_size[43:28], zero pad
  output logic             out_tuser   // count_mismatch
);

  localparam int ADDR_W = $clog2(PACKET_BYTES);

  logic                         in_xfer;
  logic [ADDR_W-1:0]            load_idx_r, load_idx_nxt;

  logic                         rd_en;
  logic [ADDR_W-1:0]            rd_addr;
  logic [7:0]                   rd_data;

  logic                         wk_idle;
  logic                         wk_done;
  logic                         wk_take;
  xfw_pkg::walk_res_t           wk_res;

  logic                         out_valid_r, out_valid_nxt;
  xfw_pkg::walk_res_t           out_res_r;

  // bytes are only taken while the walker is idle
  assign in_tready = wk_idle;
  assign in_xfer   = in_tvalid && in_tready;

  // next store address, wraps at the packet size and restarts after a last byte
  always_comb begin
    load_idx_nxt = load_idx_r;
    if (in_xfer) begin
      if (in_tlast || load_idx_r == ADDR_W'(PACKET_BYTES - 1)) begin
        load_idx_nxt = '0;
      end else begin
        load_idx_nxt = load_idx_r + ADDR_W'(1);
      end
    end
  end

  xfw_ram #(
    .WIDTH (8),
    .DEPTH (PACKET_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_xfer),
    .wr_addr (load_idx_r),
    .wr_data (in_tdata[7:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  xfw_walker #(
    .PACKET_BYTES       (PACKET_BYTES),
    .FRAME_HEADER_BITS  (FRAME_HEADER_BITS),
    .PACKET_HEADER_BITS (PACKET_HEADER_BITS)
  ) u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_xfer && in_tlast),
    .query   (in_tdata[21:8]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .idle    (wk_idle),
    .done    (wk_done),
    .take    (wk_take),
    .res     (wk_res)
  );

  // output register takes the walk result once the previous one has gone
  assign wk_take = wk_done && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (wk_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      load_idx_r  <= load_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (wk_take) begin
      out_res_r <= wk_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.size, out_res_r.frame, out_res_r.count};
  assign out_tuser  = out_res_r.mismatch;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the packet frame walker: streams whole packets,
// predicts each walk from its store copy or a typed row, checks every result
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int PKT_BYTES    = 2048;
  localparam int PKT_BITS     = PKT_BYTES * 8;
  localparam int PKT_HDR_BITS = 32;
  localparam int FRM_HDR_BITS = 15;
  localparam int FRM_HDR_ONES = (1 << FRM_HDR_BITS) - 1;
  localparam int LIMIT        = 4000000;  // cycles before the run is declared hung
  localparam int LONG_HOLD    = 400;      // receiver back-pressure stretch
  localparam int DIR_ROWS     = 16;

  // one packet to build and stream; tail < 0 means no header after the chain
  typedef struct packed {
    int nbytes;
    int raw;        // 1: no header or chain, every byte is background
    int rand_fill;  // 1: background bytes are random
    int fill;
    int hc;         // header frame count field
    int first_rel;  // first-frame offset before the header bias
    int meta;
    int fs;         // size of every chained frame
    int nframes;
    int last_cont;  // continuation bit of the last chained frame
    int tail;       // header value written right after the chain
    int query;
    int typed;      // 1: the fields below are the expected result
    int e_count;
    int e_frame;
    int e_size;
    int e_mm;
  } pkt_spec_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // packet_byte[7:0], frame_offset[21:8], zero pad
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // frame_count[13:0], current_frame[27:14],
                           // current_frame_size[43:28], zero pad
  logic        out_tuser;  // count_mismatch

  // bench copy of the block state
  logic [7:0] pkt_mem [PKT_BYTES];
  int         load_idx;

  // packet being streamed
  logic [7:0] pkt_buf [4096];
  int         pkt_len;

  xfw_pkg::walk_res_t  pending_walks [$];
  xfw_pkg::walk_res_t  head_walk;
  int                  fail_cnt  = 0;
  int                  cycle_cnt = 0;

  // directed packets, the first one fills the whole store and wraps over
  pkt_spec_t dir_pkts [DIR_ROWS] = '{
    // overlong all-zero packet: empty chain, query before the first frame
    '{2050, 1, 0, 0,   0, 0, 0,     0, 0, 0, -1,     0, 1,  0, 0,    32, 0},
    // all-ones bytes: first offset far past the packet, largest query
    '{3,    1, 0, 255, 0, 0, 0,     0, 0, 0, -1, 16383, 1,  0, 0, 16416, 0},
    // xma2 header count below the walked count
    '{24,   0, 0, 0,   1, 0, 1,    40, 3, 0, -1,    32, 1,  3, 0,    40, 1},
    // xma2 header count raises the count
    '{24,   0, 0, 0,  63, 0, 1,    40, 3, 0, -1,    72, 1, 63, 1,    40, 0},
    // chain runs to a few bits short of the end: split frame header
    '{2048, 0, 0, 0,   0, 0, 0,  2043, 8, 1, -1, 16376, 1,  9, 8,     0, 0},
    // chain ends exactly on the last bit
    '{2048, 0, 0, 0,   0, 0, 5,  2044, 8, 1, -1,    32, 1,  8, 0,  2044, 0},
    // query before the first frame
    '{40,   0, 0, 165, 0, 100, 0,  30, 2, 0, -1,    50, 0,  0, 0,     0, 0},
    // query between frame starts
    '{24,   0, 1, 0,   5, 0, 2,    30, 3, 0, -1,    33, 0,  0, 0,     0, 0},
    // zero-size header stops the walk
    '{24,   0, 1, 0,   0, 0, 0,    20, 2, 1,  0,    52, 0,  0, 0,     0, 0},
    // all-ones header stops the walk
    '{24,   0, 1, 0,   0, 0, 3,    20, 2, 1, 32767, 32, 0,  0, 0,     0, 0},
    // frame longer than what is left of the packet
    '{24,   0, 1, 0,   0, 0, 0,    40, 2, 1, 20000, 112, 0, 0, 0,     0, 0},
    // short packet whose first offset points past the store
    '{4,    0, 1, 0,   0, 30000, 0, 0, 0, 0, -1, 16383, 0,  0, 0,     0, 0},
    // short packet whose chain goes on into bytes of earlier packets
    '{6,    0, 1, 0,   0, 0, 0,    16, 1, 1, -1,    32, 0,  0, 0,     0, 0},
    // xma2 header count equal to the walked count
    '{24,   0, 1, 0,   2, 0, 1,    30, 2, 0, -1,    62, 0,  0, 0,     0, 0},
    // xma2 count raise with the query at no frame start
    '{24,   0, 1, 0,  10, 0, 1,    30, 2, 0, -1,    40, 0,  0, 0,     0, 0},
    // single-byte packet
    '{1,    1, 0, 90,  0, 0, 0,     0, 0, 0, -1,  8191, 0,  0, 0,     0, 0}
  };

  xma_packet_frame_walker #(
    .PACKET_BYTES      (PKT_BYTES),
    .FRAME_HEADER_BITS (FRM_HDR_BITS),
    .PACKET_HEADER_BITS(PKT_HDR_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // walk predictor
  // --------------------------------------------------------------------------

  // bits are numbered msb first within each byte; past the store reads zero
  function automatic bit store_bit(input int p);
    if ((p >> 3) >= PKT_BYTES) return 1'b0;
    return pkt_mem[p >> 3][7 - (p & 7)];
  endfunction

  function automatic xfw_pkg::walk_res_t frame_chain_walk(input int q);
    int b0, b1, b2, first, pos, room, cnt, frm, sz, fs, hcnt, i;
    bit split, run;
    xfw_pkg::walk_res_t r;
    b0 = pkt_mem[0];
    b1 = pkt_mem[1];
    b2 = pkt_mem[2];
    first = (((b0 & 3) << 13) | (b1 << 5) | (b2 >> 3)) + PKT_HDR_BITS;
    pos = (first < PKT_BITS) ? first : PKT_BITS;
    cnt = 0;
    frm = 0;
    sz = 0;
    split = 1'b0;
    run = 1'b1;
    // query inside the tail of a frame split from the previous packet
    if (q < first) sz = first - q;
    while (run) begin
      room = PKT_BITS - pos;
      if (room < FRM_HDR_BITS) begin
        split = (cnt > 0) && (room > 0);
        run = 1'b0;
      end else begin
        fs = 0;
        for (i = 0; i < FRM_HDR_BITS; i++) fs = (fs << 1) | store_bit(pos + i);
        if (fs == 0 || fs == FRM_HDR_ONES) begin
          run = 1'b0;
        end else begin
          if (pos == q) begin
            frm = cnt;
            sz = fs;
          end
          cnt = (cnt < int'(xfw_pkg::COUNT_MAX)) ? cnt + 1 : int'(xfw_pkg::COUNT_MAX);
          if (fs > room) begin
            run = 1'b0;
          end else begin
            // continuation bit is the last bit of the frame
            pos = pos + fs - 1;
            run = store_bit(pos);
            pos = pos + 1;
          end
        end
      end
    end
    r = '0;
    if ((b2 & 7) == int'(xfw_pkg::META_XMA2)) begin
      hcnt = b0 >> 2;
      if (hcnt > cnt) begin
        if (sz == 0) frm = cnt;
        cnt = hcnt;
      end else if (hcnt != cnt) begin
        r.mismatch = 1'b1;
      end
    end else if (split) begin
      if (sz == 0) frm = cnt;
      cnt = (cnt < int'(xfw_pkg::COUNT_MAX)) ? cnt + 1 : int'(xfw_pkg::COUNT_MAX);
    end
    r.count = xfw_pkg::COUNT_W'(cnt);
    r.frame = xfw_pkg::COUNT_W'(frm);
    r.size  = xfw_pkg::SIZE_W'(sz);
    return r;
  endfunction

  // one accepted transfer: store the byte, walk on the last one
  function automatic bit load_byte(input logic [7:0] b, input logic [13:0] q,
                                   input bit last, output xfw_pkg::walk_res_t r);
    pkt_mem[load_idx] = b;
    load_idx = (load_idx + 1) % PKT_BYTES;
    r = '0;
    if (!last) return 1'b0;
    load_idx = 0;
    r = frame_chain_walk(int'(q));
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // packet building
  // --------------------------------------------------------------------------

  function automatic void put_bits(input int pos, input int val, input int n);
    int i, p;
    for (i = 0; i < n; i++) begin
      p = pos + i;
      if (p < pkt_len * 8) pkt_buf[p >> 3][7 - (p & 7)] = val[n - 1 - i];
    end
  endfunction

  function automatic void build_packet(input pkt_spec_t s);
    int i, pos;
    pkt_len = s.nbytes;
    for (i = 0; i < s.nbytes; i++) pkt_buf[i] = (s.rand_fill != 0) ? 8'($urandom) : 8'(s.fill);
    if (s.raw == 0) begin
      // header: count[5:0], first offset[14:0], metadata[2:0], msb first
      put_bits(0, s.hc, 6);
      put_bits(6, s.first_rel, 15);
      put_bits(21, s.meta, 3);
      pos = s.first_rel + PKT_HDR_BITS;
      for (i = 0; i < s.nframes; i++) begin
        put_bits(pos, s.fs, FRM_HDR_BITS);
        put_bits(pos + s.fs - 1, (i == s.nframes - 1) ? s.last_cont : 1, 1);
        pos = pos + s.fs;
      end
      if (s.tail >= 0) put_bits(pos, s.tail, FRM_HDR_BITS);
    end
  endfunction

  // mostly well-formed chains with random content, the rest plain noise
  function automatic pkt_spec_t random_packet();
    pkt_spec_t s;
    int first, end_bit;
    s = '0;
    s.rand_fill = 1;
    s.tail = -1;
    if ($urandom_range(0, 4) == 0) begin
      s.raw = 1;
      s.nbytes = $urandom_range(1, 40);
      s.query = $urandom_range(0, 16383);
      return s;
    end
    s.hc = $urandom_range(0, 63);
    s.meta = ($urandom_range(0, 2) == 0) ? int'(xfw_pkg::META_XMA2) : $urandom_range(0, 7);
    s.first_rel = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 64);
    s.fs = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 2000) : $urandom_range(16, 120);
    s.nframes = $urandom_range(0, 6);
    s.last_cont = $urandom_range(0, 1);
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 3))
        0:       s.tail = 0;
        1:       s.tail = FRM_HDR_ONES;
        default: s.tail = $urandom_range(0, FRM_HDR_ONES);
      endcase
    end
    first = s.first_rel + PKT_HDR_BITS;
    end_bit = first + s.nframes * s.fs + ((s.tail >= 0) ? FRM_HDR_BITS : 0);
    // chains that cannot fit ride on whatever earlier packets left behind
    if (end_bit > PKT_BITS) s.nbytes = $urandom_range(3, 16);
    else s.nbytes = (end_bit + 7) / 8 + $urandom_range(0, 4);
    if (s.nbytes > PKT_BYTES) s.nbytes = PKT_BYTES;
    if ($urandom_range(0, 7) == 0) s.nbytes = $urandom_range(1, s.nbytes);
    case ($urandom_range(0, 4)) inside
      [0:1]:   s.query = first + $urandom_range(0, s.nframes) * s.fs;
      2:       s.query = first - $urandom_range(0, 40);
      3:       s.query = $urandom_range(0, 16383);
      default: s.query = first + $urandom_range(0, s.nframes) * s.fs + $urandom_range(1, 16);
    endcase
    s.query = s.query & 16383;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  task automatic send_packet(input pkt_spec_t s);
    int i, gap;
    bit burst, last;
    logic [13:0] ofs;
    xfw_pkg::walk_res_t res;
    // some packets go out back to back, others with random gaps
    burst = ($urandom_range(0, 3) == 0);
    for (i = 0; i < s.nbytes; i++) begin
      gap = burst ? 0 : $urandom_range(0, 5);
      last = (i == s.nbytes - 1);
      // the offset field only counts with the last byte, noise otherwise
      ofs = last ? 14'(s.query) : 14'($urandom);
      @(negedge clk);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= {2'b00, ofs, pkt_buf[i]};
      in_tlast  <= last;
      do @(posedge clk); while (!in_tready);
      if (load_byte(pkt_buf[i], ofs, last, res)) begin
        if (s.typed != 0) begin
          res.count    = xfw_pkg::COUNT_W'(s.e_count);
          res.frame    = xfw_pkg::COUNT_W'(s.e_frame);
          res.size     = xfw_pkg::SIZE_W'(s.e_size);
          res.mismatch = s.e_mm[0];
        end
        pending_walks.push_back(res);
      end
    end
  endtask

  initial begin : stimulus
    int r, rnd_items, rnd_walks;
    pkt_spec_t s;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    load_idx  = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed packets
    for (r = 0; r < DIR_ROWS; r++) begin
      build_packet(dir_pkts[r]);
      send_packet(dir_pkts[r]);
    end

    // random packets
    rnd_items = 0;
    rnd_walks = 0;
    while (rnd_items < 750 || rnd_walks < 40) begin
      s = random_packet();
      build_packet(s);
      send_packet(s);
      rnd_items += s.nbytes;
      rnd_walks++;
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    // drain, then leave room for any stray result
    while (pending_walks.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("xma_packet_frame_walker test passed");
    end else begin
      $display("xma_packet_frame_walker test failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------

  // random stalls per result, stretches with none, and one long hold so the
  // walker backs up and holds off its input
  initial begin : result_sink
    int taken, stall;
    bit steady;
    taken = 0;
    steady = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 16 == 0) steady = ($urandom_range(0, 2) == 0);
      stall = steady ? 0 : $urandom_range(0, 5);
      if (taken == 20) stall = LONG_HOLD;
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // compare each result transfer with the oldest predicted walk
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_walks.size() == 0) begin
        $error("result transfer with no walk pending");
        fail_cnt++;
      end else begin
        head_walk = pending_walks.pop_front();
        if (out_tdata[13:0] !== head_walk.count) begin
          $error("frame_count: expected %0d, got %0d", head_walk.count, out_tdata[13:0]);
          fail_cnt++;
        end
        if (out_tdata[27:14] !== head_walk.frame) begin
          $error("current_frame: expected %0d, got %0d", head_walk.frame, out_tdata[27:14]);
          fail_cnt++;
        end
        if (out_tdata[43:28] !== head_walk.size) begin
          $error("current_frame_size: expected %0d, got %0d",
                 head_walk.size, out_tdata[43:28]);
          fail_cnt++;
        end
        if (out_tuser !== head_walk.mismatch) begin
          $error("count_mismatch: expected %0d, got %0d", head_walk.mismatch, out_tuser);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt == LIMIT);
    $display("xma_packet_frame_walker test failed");
    $finish;
  end

endmodule

`default_nettype wire
